// ===== rtl/adaptive_traffic_phase_controller_core_assert.svh =====
// Assertion macros shared by the traffic phase controller RTL.
`ifndef ADAPTIVE_TRAFFIC_PHASE_CONTROLLER_CORE_ASSERT_SVH
`define ADAPTIVE_TRAFFIC_PHASE_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("controller assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ATPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("controller assertion failed");

`endif

// ===== rtl/atpc_pkg.sv =====
// Shared widths, codes, reset values and helpers of the traffic phase controller.
package atpc_pkg;

  localparam int TIME_BITS    = 20;
  localparam int COUNT_BITS   = 8;
  localparam int SUM_BITS     = COUNT_BITS + 1;
  localparam int REG_BITS     = 20;
  localparam int PVT_BITS     = 12;
  localparam int ELAPSED_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int PROD_BITS    = SUM_BITS + PVT_BITS;
  localparam int GREEN_BITS   = ((PROD_BITS > REG_BITS) ? PROD_BITS : REG_BITS) + 1;
  localparam int SAT_BITS     = (TIME_BITS > REG_BITS) ? TIME_BITS : REG_BITS;
  localparam int CMP_BITS     = (TIME_BITS > ELAPSED_BITS) ? TIME_BITS : ELAPSED_BITS;

  localparam logic [SAT_BITS-1:0] TIME_MAX_W = SAT_BITS'((64'd1 << TIME_BITS) - 64'd1);

  typedef enum logic [1:0] {
    PH_NS_GREEN  = 2'd0,
    PH_NS_YELLOW = 2'd1,
    PH_EW_GREEN  = 2'd2,
    PH_EW_YELLOW = 2'd3
  } phase_t;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_FORCE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FIXED_MODE  = 3'd0,
    REG_BASE_GREEN  = 3'd1,
    REG_PER_VEHICLE = 3'd2,
    REG_MIN_GREEN   = 3'd3,
    REG_MAX_GREEN   = 3'd4,
    REG_FIXED_GREEN = 3'd5,
    REG_AMBER_MS    = 3'd6
  } cfg_reg_t;

  localparam logic [REG_BITS-1:0] RST_BASE_GREEN  = REG_BITS'(10000);
  localparam logic [PVT_BITS-1:0] RST_PER_VEHICLE = PVT_BITS'(500);
  localparam logic [REG_BITS-1:0] RST_MIN_GREEN   = REG_BITS'(5000);
  localparam logic [REG_BITS-1:0] RST_MAX_GREEN   = REG_BITS'(60000);
  localparam logic [REG_BITS-1:0] RST_FIXED_GREEN = REG_BITS'(30000);
  localparam logic [REG_BITS-1:0] RST_AMBER_MS    = REG_BITS'(3000);

  // Clips a register-width duration to the time field.
  function automatic logic [TIME_BITS-1:0] sat_time(input logic [REG_BITS-1:0] v);
    logic [SAT_BITS-1:0] wide;
    wide = SAT_BITS'(v);
    if (wide > TIME_MAX_W) begin
      return {TIME_BITS{1'b1}};
    end
    return wide[TIME_BITS-1:0];
  endfunction

endpackage

// ===== rtl/atpc_in_if.sv =====
// Request channel carrying one tick or force item into the controller.
interface atpc_in_if;
  import atpc_pkg::*;

  logic                    valid;
  logic                    ready;
  cmd_t                    command;
  logic [ELAPSED_BITS-1:0] elapsed_ms;
  logic [COUNT_BITS-1:0]   north_count;
  logic [COUNT_BITS-1:0]   south_count;
  logic [COUNT_BITS-1:0]   east_count;
  logic [COUNT_BITS-1:0]   west_count;
  phase_t                  forced_phase;
  logic [REG_BITS-1:0]     forced_duration;

  modport source (
    output valid, command, elapsed_ms, north_count, south_count, east_count, west_count,
           forced_phase, forced_duration,
    input  ready
  );

  modport sink (
    input  valid, command, elapsed_ms, north_count, south_count, east_count, west_count,
           forced_phase, forced_duration,
    output ready
  );
endinterface

// ===== rtl/atpc_out_if.sv =====
// Result channel carrying the controller status after each request.
interface atpc_out_if;
  import atpc_pkg::*;

  logic                 valid;
  logic                 ready;
  phase_t               phase;
  logic [TIME_BITS-1:0] time_left;
  logic [TIME_BITS-1:0] phase_length;
  logic [SUM_BITS-1:0]  ns_total;
  logic [SUM_BITS-1:0]  ew_total;

  modport source (
    output valid, phase, time_left, phase_length, ns_total, ew_total,
    input  ready
  );

  modport sink (
    input  valid, phase, time_left, phase_length, ns_total, ew_total,
    output ready
  );
endinterface

// ===== rtl/atpc_cfg_if.sv =====
// Configuration write channel of the controller.
interface atpc_cfg_if;
  import atpc_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [REG_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/adaptive_traffic_phase_controller_core.sv =====
// Four-phase adaptive traffic signal controller core.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------------
//  in_ch    | in  | in_ch.valid/in_ch.ready | command, elapsed, four counts, force data
//  out_ch   | out | out_ch.valid/ready      | phase, time_left, phase_length, totals
//  cfg_ch   | in  | cfg_ch.valid/ready      | register index, write data
//
// A request is captured in an input register and resolved from there into the state
// registers, which also serve as the result register. Unless out_ch stalls, throughput
// is one request per cycle, set by the single adder/multiplier/clamp pass.
// A result that is not taken holds the state; the input register still takes one more.
// Synchronous active-low reset restores the register defaults and NS green.
// Configuration writes are always ready and take effect in the next cycle.
module adaptive_traffic_phase_controller_core (
  input logic clk,
  input logic rst_n,
  atpc_in_if.sink    in_ch,
  atpc_out_if.source out_ch,
  atpc_cfg_if.sink   cfg_ch
);
  import atpc_pkg::*;

  `include "adaptive_traffic_phase_controller_core_assert.svh"

  // Configuration registers.
  logic                fixed_mode_r;
  logic [REG_BITS-1:0] base_green_r;
  logic [PVT_BITS-1:0] per_vehicle_r;
  logic [REG_BITS-1:0] min_green_r;
  logic [REG_BITS-1:0] max_green_r;
  logic [REG_BITS-1:0] fixed_green_r;
  logic [REG_BITS-1:0] amber_ms_r;

  // Input register.
  logic                    s1_valid_r;
  cmd_t                    s1_cmd_r;
  logic [ELAPSED_BITS-1:0] s1_elapsed_r;
  logic [COUNT_BITS-1:0]   s1_north_r;
  logic [COUNT_BITS-1:0]   s1_south_r;
  logic [COUNT_BITS-1:0]   s1_east_r;
  logic [COUNT_BITS-1:0]   s1_west_r;
  phase_t                  s1_fphase_r;
  logic [REG_BITS-1:0]     s1_fdur_r;

  // Controller state, presented directly as the result payload.
  logic                 out_valid_r;
  phase_t               phase_r;
  logic [TIME_BITS-1:0] countdown_r;
  logic [TIME_BITS-1:0] duration_r;
  logic [SUM_BITS-1:0]  ns_sum_r;
  logic [SUM_BITS-1:0]  ew_sum_r;

  phase_t               phase_nxt;
  logic [TIME_BITS-1:0] countdown_nxt;
  logic [TIME_BITS-1:0] duration_nxt;
  logic [SUM_BITS-1:0]  ns_sum_nxt;
  logic [SUM_BITS-1:0]  ew_sum_nxt;

  logic                 in_fire;
  logic                 advance;
  logic                 expired;
  logic                 tick_hit;
  logic                 tick_run;
  logic [SUM_BITS-1:0]  tick_ns;
  logic [SUM_BITS-1:0]  tick_ew;
  logic [SUM_BITS-1:0]  cars;
  logic [PROD_BITS-1:0] prod;
  logic [GREEN_BITS-1:0] green_raw;
  logic [REG_BITS-1:0]  green_clamped;
  logic [TIME_BITS-1:0] green_time;
  logic [TIME_BITS-1:0] yellow_sat;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign tick_hit = advance && (s1_cmd_r == CMD_TICK) && expired;
  assign tick_run = advance && (s1_cmd_r == CMD_TICK) && !expired;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.phase        = phase_r;
  assign out_ch.time_left    = countdown_r;
  assign out_ch.phase_length = duration_r;
  assign out_ch.ns_total     = ns_sum_r;
  assign out_ch.ew_total     = ew_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_mode_r  <= 1'b0;
      base_green_r  <= RST_BASE_GREEN;
      per_vehicle_r <= RST_PER_VEHICLE;
      min_green_r   <= RST_MIN_GREEN;
      max_green_r   <= RST_MAX_GREEN;
      fixed_green_r <= RST_FIXED_GREEN;
      amber_ms_r    <= RST_AMBER_MS;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_FIXED_MODE:  fixed_mode_r  <= cfg_ch.data[0];
        REG_BASE_GREEN:  base_green_r  <= cfg_ch.data;
        REG_PER_VEHICLE: per_vehicle_r <= cfg_ch.data[PVT_BITS-1:0];
        REG_MIN_GREEN:   min_green_r   <= cfg_ch.data;
        REG_MAX_GREEN:   max_green_r   <= cfg_ch.data;
        REG_FIXED_GREEN: fixed_green_r <= cfg_ch.data;
        REG_AMBER_MS:    amber_ms_r    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r     <= in_ch.command;
      s1_elapsed_r <= in_ch.elapsed_ms;
      s1_north_r   <= in_ch.north_count;
      s1_south_r   <= in_ch.south_count;
      s1_east_r    <= in_ch.east_count;
      s1_west_r    <= in_ch.west_count;
      s1_fphase_r  <= in_ch.forced_phase;
      s1_fdur_r    <= in_ch.forced_duration;
    end
  end

  always_comb begin
    tick_ns = SUM_BITS'(s1_north_r) + SUM_BITS'(s1_south_r);
    tick_ew = SUM_BITS'(s1_east_r) + SUM_BITS'(s1_west_r);
    expired = !(CMP_BITS'(countdown_r) > CMP_BITS'(s1_elapsed_r));

    // Only the green that follows a yellow is ever needed: EW after NS yellow, NS after EW.
    cars = (phase_r == PH_NS_YELLOW) ? tick_ew : tick_ns;
    prod = PROD_BITS'(cars) * PROD_BITS'(per_vehicle_r);
    green_raw = GREEN_BITS'(base_green_r) + GREEN_BITS'(prod);
    if (green_raw > GREEN_BITS'(max_green_r)) begin
      green_clamped = max_green_r;
    end else begin
      green_clamped = green_raw[REG_BITS-1:0];
    end
    // The lower limit is applied last, so it wins when it exceeds the upper one.
    if (green_clamped < min_green_r) begin
      green_clamped = min_green_r;
    end
    green_time = fixed_mode_r ? sat_time(fixed_green_r) : sat_time(green_clamped);
    yellow_sat = sat_time(amber_ms_r);

    phase_nxt     = phase_r;
    countdown_nxt = countdown_r;
    duration_nxt  = duration_r;
    ns_sum_nxt    = ns_sum_r;
    ew_sum_nxt    = ew_sum_r;

    if (s1_cmd_r == CMD_FORCE) begin
      phase_nxt     = s1_fphase_r;
      duration_nxt  = sat_time(s1_fdur_r);
      countdown_nxt = sat_time(s1_fdur_r);
    end else begin
      ns_sum_nxt = tick_ns;
      ew_sum_nxt = tick_ew;
      if (!expired) begin
        countdown_nxt = countdown_r - TIME_BITS'(s1_elapsed_r);
      end else begin
        // Overshoot past zero is dropped; the new phase starts with its full length.
        case (phase_r)
          PH_NS_GREEN: begin
            phase_nxt    = PH_NS_YELLOW;
            duration_nxt = yellow_sat;
          end
          PH_NS_YELLOW: begin
            phase_nxt    = PH_EW_GREEN;
            duration_nxt = green_time;
          end
          PH_EW_GREEN: begin
            phase_nxt    = PH_EW_YELLOW;
            duration_nxt = yellow_sat;
          end
          default: begin
            phase_nxt    = PH_NS_GREEN;
            duration_nxt = green_time;
          end
        endcase
        countdown_nxt = duration_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= PH_NS_GREEN;
      countdown_r <= sat_time(RST_BASE_GREEN);
      duration_r  <= sat_time(RST_BASE_GREEN);
      ns_sum_r    <= '0;
      ew_sum_r    <= '0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        phase_r     <= phase_nxt;
        countdown_r <= countdown_nxt;
        duration_r  <= duration_nxt;
        ns_sum_r    <= ns_sum_nxt;
        ew_sum_r    <= ew_sum_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `ATPC_ASSERT_NOW(a_countdown_within_length, clk, rst_n, 1'b1, countdown_r <= duration_r)
  `ATPC_ASSERT_NEXT(a_advance_gives_result, clk, rst_n, advance, out_valid_r)
  `ATPC_ASSERT_NEXT(a_expiry_steps, clk, rst_n, tick_hit, phase_r == 2'($past(phase_r) + 2'd1))
  `ATPC_ASSERT_NEXT(a_phase_holds, clk, rst_n, tick_run, $stable(phase_r) && $stable(duration_r))

endmodule

// ===== tb/atpc_status_checker_pkg.sv =====
`timescale 1ns / 100ps
// Status predictor and result checker used by the traffic phase controller testbench.
package atpc_status_checker_pkg;
  import atpc_pkg::*;

  typedef struct {
    cmd_t                    command;
    logic [ELAPSED_BITS-1:0] elapsed_ms;
    logic [COUNT_BITS-1:0]   north;
    logic [COUNT_BITS-1:0]   south;
    logic [COUNT_BITS-1:0]   east;
    logic [COUNT_BITS-1:0]   west;
    phase_t                  forced_phase;
    logic [REG_BITS-1:0]     forced_duration;
  } request_t;

  typedef struct {
    phase_t               phase;
    logic [TIME_BITS-1:0] time_left;
    logic [TIME_BITS-1:0] phase_length;
    logic [SUM_BITS-1:0]  ns_total;
    logic [SUM_BITS-1:0]  ew_total;
  } status_t;

  class phase_status_checker;
    bit                   fixed_mode;
    logic [REG_BITS-1:0]  base_green;
    logic [PVT_BITS-1:0]  per_vehicle;
    logic [REG_BITS-1:0]  min_green;
    logic [REG_BITS-1:0]  max_green;
    logic [REG_BITS-1:0]  fixed_green;
    logic [REG_BITS-1:0]  amber_ms;

    phase_t               cur_phase;
    logic [TIME_BITS-1:0] countdown;
    logic [TIME_BITS-1:0] phase_len;
    logic [SUM_BITS-1:0]  ns_sum;
    logic [SUM_BITS-1:0]  ew_sum;

    status_t              expected_q[$];
    int                   mismatches;

    function new();
      mismatches = 0;
      fixed_mode  = 1'b0;
      base_green  = RST_BASE_GREEN;
      per_vehicle = RST_PER_VEHICLE;
      min_green   = RST_MIN_GREEN;
      max_green   = RST_MAX_GREEN;
      fixed_green = RST_FIXED_GREEN;
      amber_ms    = RST_AMBER_MS;
      cur_phase   = PH_NS_GREEN;
      countdown   = clip_time(64'(RST_BASE_GREEN));
      phase_len   = countdown;
      ns_sum      = '0;
      ew_sum      = '0;
    endfunction

    function logic [TIME_BITS-1:0] clip_time(input logic [63:0] v);
      logic [63:0] top;
      top = (64'd1 << TIME_BITS) - 64'd1;
      return (v > top) ? top[TIME_BITS-1:0] : v[TIME_BITS-1:0];
    endfunction

    // Adaptive time is capped at max first and then raised to min, so min wins.
    function logic [TIME_BITS-1:0] green_for(input logic [SUM_BITS-1:0] cars);
      logic [63:0] t;
      if (fixed_mode) begin
        return clip_time(64'(fixed_green));
      end
      t = 64'(base_green) + 64'(cars) * 64'(per_vehicle);
      if (t > 64'(max_green)) begin
        t = 64'(max_green);
      end
      if (t < 64'(min_green)) begin
        t = 64'(min_green);
      end
      return clip_time(t);
    endfunction

    function void enter_phase(input phase_t p, input logic [TIME_BITS-1:0] dur);
      cur_phase = p;
      phase_len = dur;
      countdown = dur;
    endfunction

    function void write_register(input logic [CFG_IDX_BITS-1:0] idx,
                                 input logic [REG_BITS-1:0] data);
      case (idx)
        REG_FIXED_MODE:  fixed_mode  = data[0];
        REG_BASE_GREEN:  base_green  = data;
        REG_PER_VEHICLE: per_vehicle = data[PVT_BITS-1:0];
        REG_MIN_GREEN:   min_green   = data;
        REG_MAX_GREEN:   max_green   = data;
        REG_FIXED_GREEN: fixed_green = data;
        REG_AMBER_MS:    amber_ms    = data;
        default: ;
      endcase
    endfunction

    function void note_request(input request_t r);
      status_t s;
      if (r.command == CMD_FORCE) begin
        enter_phase(r.forced_phase, clip_time(64'(r.forced_duration)));
      end else begin
        ns_sum = SUM_BITS'(r.north) + SUM_BITS'(r.south);
        ew_sum = SUM_BITS'(r.east) + SUM_BITS'(r.west);
        if (64'(countdown) > 64'(r.elapsed_ms)) begin
          countdown = TIME_BITS'(64'(countdown) - 64'(r.elapsed_ms));
        end else begin
          // Expired: any overshoot is dropped and the next phase starts full.
          case (cur_phase)
            PH_NS_GREEN:  enter_phase(PH_NS_YELLOW, clip_time(64'(amber_ms)));
            PH_NS_YELLOW: enter_phase(PH_EW_GREEN, green_for(ew_sum));
            PH_EW_GREEN:  enter_phase(PH_EW_YELLOW, clip_time(64'(amber_ms)));
            default:      enter_phase(PH_NS_GREEN, green_for(ns_sum));
          endcase
        end
      end
      s.phase        = cur_phase;
      s.time_left    = countdown;
      s.phase_length = phase_len;
      s.ns_total     = ns_sum;
      s.ew_total     = ew_sum;
      expected_q.push_back(s);
    endfunction

    task report(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
        report($sformatf("%s got %0d, expected %0d", name, got, want));
      end
    endtask

    task check_status(input status_t got);
      status_t want;
      if (expected_q.size() == 0) begin
        report("status returned with no request outstanding");
        return;
      end
      want = expected_q.pop_front();
      compare_field("phase", 32'(got.phase), 32'(want.phase));
      compare_field("time_left", 32'(got.time_left), 32'(want.time_left));
      compare_field("phase_length", 32'(got.phase_length), 32'(want.phase_length));
      compare_field("ns_total", 32'(got.ns_total), 32'(want.ns_total));
      compare_field("ew_total", 32'(got.ew_total), 32'(want.ew_total));
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    task finish_check();
      if (expected_q.size() != 0) begin
        report($sformatf("%0d statuses never returned", expected_q.size()));
      end
    endtask
  endclass

endpackage

// ===== tb/adaptive_traffic_phase_controller_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the adaptive traffic phase controller core.
module adaptive_traffic_phase_controller_core_test;
  import atpc_pkg::*;
  import atpc_status_checker_pkg::*;

  localparam int IDLE_LIMIT        = 2000;
  localparam int NUM_PROFILES      = 9;
  localparam int ITEMS_PER_PROFILE = 110;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED   = 3'd7;
  localparam logic [REG_BITS-1:0]     REG_ALL_ONES = '1;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  atpc_in_if  in_ch();
  atpc_out_if out_ch();
  atpc_cfg_if cfg_ch();

  phase_status_checker sb = new();

  int burst_left  = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  adaptive_traffic_phase_controller_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always @(posedge clk) begin
    request_t r;
    status_t  s;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      r.command         = in_ch.command;
      r.elapsed_ms      = in_ch.elapsed_ms;
      r.north           = in_ch.north_count;
      r.south           = in_ch.south_count;
      r.east            = in_ch.east_count;
      r.west            = in_ch.west_count;
      r.forced_phase    = in_ch.forced_phase;
      r.forced_duration = in_ch.forced_duration;
      sb.note_request(r);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      s.phase        = out_ch.phase;
      s.time_left    = out_ch.time_left;
      s.phase_length = out_ch.phase_length;
      s.ns_total     = out_ch.ns_total;
      s.ew_total     = out_ch.ew_total;
      sb.check_status(s);
    end
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      sb.write_register(cfg_ch.index, cfg_ch.data);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("adaptive_traffic_phase_controller_core_test failed");
      $finish;
    end
  end

  // The status side alternates between always ready, sparse stalls and long stall runs.
  initial begin : status_sink
    int  mode;
    int  span;
    int  run_left;
    bit  level;
    out_ch.ready = 1'b0;
    run_left = 0;
    level = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(32, 200);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ch.ready = 1'b1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          default: begin
            if (run_left == 0) begin
              level = !level;
              run_left = level ? $urandom_range(1, 8) : $urandom_range(1, 24);
            end
            run_left--;
            out_ch.ready = level;
          end
        endcase
      end
    end
  end

  function automatic request_t make_tick(input logic [ELAPSED_BITS-1:0] el,
                                         input logic [COUNT_BITS-1:0] n,
                                         input logic [COUNT_BITS-1:0] s,
                                         input logic [COUNT_BITS-1:0] e,
                                         input logic [COUNT_BITS-1:0] w);
    request_t r;
    r.command         = CMD_TICK;
    r.elapsed_ms      = el;
    r.north           = n;
    r.south           = s;
    r.east            = e;
    r.west            = w;
    r.forced_phase    = phase_t'($urandom_range(0, 3));
    r.forced_duration = REG_BITS'($urandom);
    return r;
  endfunction

  // Count and elapsed fields are filled with noise; a force request must ignore them.
  function automatic request_t make_force(input phase_t p, input logic [REG_BITS-1:0] dur);
    request_t r;
    r = make_tick(ELAPSED_BITS'($urandom), COUNT_BITS'($urandom), COUNT_BITS'($urandom),
                  COUNT_BITS'($urandom), COUNT_BITS'($urandom));
    r.command         = CMD_FORCE;
    r.forced_phase    = p;
    r.forced_duration = dur;
    return r;
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return COUNT_BITS'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    logic [ELAPSED_BITS-1:0] el;
    logic [REG_BITS-1:0]     dur;
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       dur = '0;
        1:       dur = REG_BITS'($urandom_range(0, 100));
        2:       dur = REG_BITS'($urandom_range(0, 70000));
        default: dur = REG_BITS'($urandom);
      endcase
      return make_force(phase_t'($urandom_range(0, 3)), dur);
    end
    case ($urandom_range(0, 4))
      0:       el = ELAPSED_BITS'($urandom_range(0, 16));
      1:       el = ELAPSED_BITS'($urandom_range(0, 4000));
      2:       el = ELAPSED_BITS'($urandom_range(60000, 65535));
      default: el = ELAPSED_BITS'($urandom);
    endcase
    return make_tick(el, pick_count(), pick_count(), pick_count(), pick_count());
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.command         = r.command;
    in_ch.elapsed_ms      = r.elapsed_ms;
    in_ch.north_count     = r.north;
    in_ch.south_count     = r.south;
    in_ch.east_count      = r.east;
    in_ch.west_count      = r.west;
    in_ch.forced_phase    = r.forced_phase;
    in_ch.forced_duration = r.forced_duration;
    in_ch.valid           = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [REG_BITS-1:0] data);
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    cfg_ch.valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Unused upper data bits carry noise so that register masking is exercised.
  task automatic load_profile(input bit mode, input logic [REG_BITS-1:0] base,
                              input logic [PVT_BITS-1:0] pvt,
                              input logic [REG_BITS-1:0] min_g,
                              input logic [REG_BITS-1:0] max_g,
                              input logic [REG_BITS-1:0] fixed_g,
                              input logic [REG_BITS-1:0] yellow);
    cfg_write(REG_FIXED_MODE, {(REG_BITS-1)'($urandom), mode});
    cfg_write(REG_BASE_GREEN, base);
    cfg_write(REG_PER_VEHICLE, {(REG_BITS-PVT_BITS)'($urandom), pvt});
    cfg_write(REG_MIN_GREEN, min_g);
    cfg_write(REG_MAX_GREEN, max_g);
    cfg_write(REG_FIXED_GREEN, fixed_g);
    cfg_write(REG_AMBER_MS, yellow);
    cfg_write(REG_UNUSED, REG_BITS'($urandom));
    cfg_ch.valid = 1'b0;
    repeat (2) @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.command         = CMD_TICK;
    in_ch.elapsed_ms      = '0;
    in_ch.north_count     = '0;
    in_ch.south_count     = '0;
    in_ch.east_count      = '0;
    in_ch.west_count      = '0;
    in_ch.forced_phase    = PH_NS_GREEN;
    in_ch.forced_duration = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_FIXED_MODE;
    cfg_ch.data           = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests under the reset register values.
    send_request(make_tick(16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_tick(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_tick(16'd2999, 8'd1, 8'd2, 8'd3, 8'd4));
    send_request(make_tick(16'd1, 8'd0, 8'd0, 8'hFF, 8'hFF));
    send_request(make_force(PH_EW_YELLOW, '0));
    send_request(make_tick(16'd0, 8'd3, 8'd4, 8'd0, 8'd0));
    send_request(make_tick(16'd13499, 8'd9, 8'd0, 8'd0, 8'd9));
    send_request(make_tick(16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_request(make_force(PH_NS_YELLOW, REG_ALL_ONES));
    send_request(make_tick(16'hFFFF, 8'h80, 8'h7F, 8'h55, 8'hAA));
    send_request(make_force(PH_EW_GREEN, 20'd1));
    send_request(make_tick(16'd1, 8'hFF, 8'hFF, 8'd0, 8'd0));
    send_request(make_force(PH_NS_GREEN, 20'd12345));
    send_request(make_tick(16'hFFFF, 8'd0, 8'd0, 8'd0, 8'd0));
    drain();

    for (int p = 0; p < NUM_PROFILES; p++) begin
      case (p)
        0: ;
        1: load_profile(1'b0, '0, '0, '0, '0, '0, '0);
        2: load_profile(1'b1, REG_ALL_ONES, '1, REG_ALL_ONES, REG_ALL_ONES, REG_ALL_ONES,
                        REG_ALL_ONES);
        3: begin
          // Min above max: the loaded green time must come out as min.
          load_profile(1'b0, 20'd10000, 12'd100, 20'd40000, 20'd20000, 20'd9000, 20'd500);
          send_request(make_force(PH_EW_YELLOW, '0));
          send_request(make_tick(16'd0, 8'd0, 8'd0, 8'd0, 8'd0));
        end
        4: load_profile(1'b0, REG_ALL_ONES, '1, '0, REG_ALL_ONES, '0, 20'd1);
        5: load_profile(1'b1, 20'd2000, 12'd250, 20'd3000, 20'd30000, 20'd7000, 20'd1000);
        6: load_profile(1'b0, 20'd2000, 12'd250, 20'd3000, 20'd30000, 20'd7000, 20'd2000);
        default: load_profile(1'($urandom_range(0, 1)), REG_BITS'($urandom_range(0, 40000)),
                              PVT_BITS'($urandom), REG_BITS'($urandom_range(0, 30000)),
                              REG_BITS'($urandom_range(0, 90000)),
                              REG_BITS'($urandom_range(0, 60000)),
                              REG_BITS'($urandom_range(0, 8000)));
      endcase
      repeat (ITEMS_PER_PROFILE) send_request(random_request());
      drain();
    end

    sb.finish_check();
    if (sb.mismatches == 0) begin
      $display("adaptive_traffic_phase_controller_core_test passed");
    end else begin
      $display("adaptive_traffic_phase_controller_core_test failed");
    end
    $finish;
  end

endmodule

// ===== adaptive_traffic_phase_controller_core.f =====
+incdir+rtl
rtl/atpc_pkg.sv
rtl/atpc_in_if.sv
rtl/atpc_out_if.sv
rtl/atpc_cfg_if.sv
rtl/adaptive_traffic_phase_controller_core.sv
tb/atpc_status_checker_pkg.sv
tb/adaptive_traffic_phase_controller_core_test.sv
